/* hw/rtl/mssd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mssd_pkg
// Types and constants for the multiplexed seven-segment seconds display core.
// ----------------------------------------------------------------------------
package mssd_pkg;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_SET  = 1'b1
  } func_e;

  typedef struct packed {
    func_e       func;
    logic [15:0] new_value;
  } mssd_in_t;

  typedef struct packed {
    logic [6:0]  segments;
    logic [1:0]  digit_index;
    logic [13:0] shown_number;
  } mssd_out_t;

  localparam logic [13:0] MaxShown   = 14'd9999;
  localparam logic [15:0] TicksReset = 16'd1000;

  localparam logic [1:0] PosThousands = 2'd0;
  localparam logic [1:0] PosHundreds  = 2'd1;
  localparam logic [1:0] PosTens      = 2'd2;
  localparam logic [1:0] PosUnits     = 2'd3;

  // ceil(2^24 / d); exact quotient for every dividend up to 9999
  localparam int unsigned RecipShift = 24;
  localparam logic [20:0] Recip1000  = 21'd16778;
  localparam logic [20:0] Recip100   = 21'd167773;
  localparam logic [20:0] Recip10    = 21'd1677722;

  // active-high a..g, bit0 = a
  function automatic logic [6:0] seg_of(input logic [3:0] digit);
    logic [6:0] seg;
    case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/muxed_seven_segment_seconds_display_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// muxed_seven_segment_seconds_display_core
// A tick transaction's result is registered in stage 1 and then in the output register.
// One transaction per cycle while the output is not stalled; set transactions give no result.
// The pipeline is built around the two reciprocal multiplies (quotient, then digit).
// Reset clears counters, shown value and pipeline; ticks_per_count returns to 1000.
// ----------------------------------------------------------------------------
module muxed_seven_segment_seconds_display_core
  import mssd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire mssd_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output mssd_out_t      out_data_o,
  input  wire logic      cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  logic [15:0] tpc_q;
  logic [13:0] shown_q, shown_d;
  logic [1:0]  pos_q, pos_d;
  logic [15:0] cnt_q, cnt_d;

  logic        s1_valid_q, s1_valid_d;
  logic [13:0] s1_quot_q, s1_quot_d;
  logic [1:0]  s1_pos_q;
  logic [13:0] s1_shown_q;

  logic        out_valid_q, out_valid_d;
  mssd_out_t   out_q, out_d;

  logic adv_out, adv_s1, in_fire, tick_fire, set_fire;

  assign adv_out   = !out_valid_q || out_ready_i;
  assign adv_s1    = !s1_valid_q || adv_out;
  assign in_ready_o = adv_s1;
  assign in_fire   = in_valid_i && adv_s1;
  assign tick_fire = in_fire && (in_data_i.func == FUNC_TICK);
  assign set_fire  = in_fire && (in_data_i.func == FUNC_SET);

  // state update
  logic [15:0] cnt_inc;
  logic        roll;
  always_comb begin
    cnt_inc = cnt_q + 16'd1;
    roll    = (cnt_inc >= tpc_q) || (cnt_inc == 16'd0);
    shown_d = shown_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    if (set_fire) begin
      shown_d = (in_data_i.new_value > {2'b00, MaxShown}) ? MaxShown
                                                          : in_data_i.new_value[13:0];
    end else if (tick_fire) begin
      pos_d = pos_q + 2'd1;
      if (roll) begin
        cnt_d   = 16'd0;
        shown_d = (shown_q >= MaxShown) ? 14'd0 : shown_q + 14'd1;
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  // stage 1: quotient by the place value of the current digit
  logic [20:0] recip1;
  logic [34:0] prod1;
  always_comb begin
    case (pos_q)
      PosThousands: recip1 = Recip1000;
      PosHundreds:  recip1 = Recip100;
      PosTens:      recip1 = Recip10;
      default:      recip1 = 21'd0;
    endcase
    prod1 = 35'(shown_q) * 35'(recip1);
    if (pos_q == PosUnits) begin
      s1_quot_d = shown_q;
    end else begin
      s1_quot_d = {3'b000, prod1[34:RecipShift]};
    end
    s1_valid_d = adv_s1 ? tick_fire : s1_valid_q;
  end

  // stage 2: quotient mod 10 and segment lookup
  logic [34:0] prod2;
  logic [10:0] q10;
  logic [13:0] q10x10;
  logic [13:0] rem;
  always_comb begin
    prod2  = 35'(s1_quot_q) * 35'(Recip10);
    q10    = prod2[34:RecipShift];
    q10x10 = {q10, 3'b000} + {2'b00, q10, 1'b0};
    rem    = s1_quot_q - q10x10;
    out_d.segments     = seg_of(rem[3:0]);
    out_d.digit_index  = s1_pos_q;
    out_d.shown_number = s1_shown_q;
    out_valid_d = adv_out ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpc_q       <= TicksReset;
      shown_q     <= 14'd0;
      pos_q       <= 2'd0;
      cnt_q       <= 16'd0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tpc_q <= cfg_wdata_i;
      end
      shown_q     <= shown_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_s1 && tick_fire) begin
      s1_quot_q  <= s1_quot_d;
      s1_pos_q   <= pos_q;
      s1_shown_q <= shown_q;
    end
    if (adv_out && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // assertions
  a_shown_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    shown_q <= MaxShown) else $error("shown value out of range");

  a_set_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_fire |=> !s1_valid_q) else $error("set transaction launched a result");

  a_pos_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_fire |=> pos_q == $past(pos_q) + 2'd1) else $error("digit position did not step");

  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv_out) |=> s1_valid_q && $stable(s1_quot_q) && $stable(s1_pos_q))
    else $error("stage 1 lost data under stall");

  a_out_digit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.segments != 7'h00) else $error("digit out of decimal range");

endmodule
`default_nettype wire
